### sv/dbs_pkg.sv
// Shared types, widths and status codes for the duplicate-rejecting stack.
package dbs_pkg;

  localparam int DATA_W        = 32;
  localparam int COUNT_W       = 4;
  localparam int DEPTH_DEFAULT = 8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic                     is_pop;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage

### sv/dbs_front.sv
// Front end: takes input words, decodes them into commands and queues up to two of them.
module dbs_front
  import dbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     kind,
  input  logic signed [DATA_W-1:0] push_value,
  output logic                     cmd_valid,
  output cmd_t                     cmd,
  input  logic                     cmd_take
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;
  logic       push;
  logic       pop;
  cmd_t       decoded;

  assign in_stall  = (used == 2'd2);
  assign cmd_valid = (used != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_take && cmd_valid;

  // drop the payload of a pop so the back end sees a clean command
  always_comb begin
    decoded.is_pop = kind;
    decoded.value  = kind ? '0 : push_value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   used <= used + 2'd1;
        2'b01:   used <= used - 2'd1;
        default: used <= used;
      endcase
    end
  end

endmodule

### sv/dbs_back.sv
// Back end: stack memory, duplicate scan, fill count and result register.
module dbs_back
  import dbs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  input  cmd_t                     cmd,
  output logic                     cmd_take,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] top_value,
  output logic [COUNT_W-1:0]       count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [FW-1:0] FULL = FW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_TOP  = 2'd2;

  logic signed [DATA_W-1:0] entries [DEPTH];
  logic signed [DATA_W-1:0] rd_data;

  logic [1:0]               state, state_next;
  logic [FW-1:0]            fill, fill_next;
  logic [AW-1:0]            scan_idx, scan_idx_next;
  logic signed [DATA_W-1:0] cur_value, cur_value_next;
  logic [1:0]               res_status, res_status_next;

  logic [FW-1:0]            fill_m1;
  logic [FW-1:0]            fill_m2;
  logic                     out_free;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic signed [DATA_W-1:0] wr_data;
  logic                     emit;
  logic [1:0]               e_status;
  logic signed [DATA_W-1:0] e_top;

  assign fill_m1  = fill - 1'b1;
  assign fill_m2  = fill_m1 - 1'b1;
  assign out_free = !out_valid || !out_stall;
  assign cmd_take = (state == S_IDLE) && cmd_valid && out_free;

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    scan_idx_next   = scan_idx;
    cur_value_next  = cur_value;
    res_status_next = res_status;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_data         = cur_value;
    emit            = 1'b0;
    e_status        = ST_OK;
    e_top           = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_take) begin
          cur_value_next = cmd.value;
          if (!cmd.is_pop) begin
            if (fill == FULL) begin
              res_status_next = ST_FULL;
              rd_en           = 1'b1;
              rd_addr         = fill_m1[AW-1:0];
              state_next      = S_TOP;
            end else if (fill == '0) begin
              wr_en     = 1'b1;
              wr_data   = cmd.value;
              fill_next = fill + 1'b1;
              emit      = 1'b1;
              e_top     = cmd.value;
            end else begin
              rd_en         = 1'b1;
              rd_addr       = '0;
              scan_idx_next = '0;
              state_next    = S_SCAN;
            end
          end else begin
            if (fill == '0) begin
              emit     = 1'b1;
              e_status = ST_EMPTY;
            end else if (fill_m1 == '0) begin
              fill_next = '0;
              emit      = 1'b1;
            end else begin
              fill_next       = fill_m1;
              res_status_next = ST_OK;
              rd_en           = 1'b1;
              rd_addr         = fill_m2[AW-1:0];
              state_next      = S_TOP;
            end
          end
        end
      end
      S_SCAN: begin
        if (rd_data == cur_value) begin
          // duplicate found: fetch the unchanged top
          res_status_next = ST_DUP;
          rd_en           = 1'b1;
          rd_addr         = fill_m1[AW-1:0];
          state_next      = S_TOP;
        end else if (scan_idx == fill_m1[AW-1:0]) begin
          if (out_free) begin
            wr_en      = 1'b1;
            fill_next  = fill + 1'b1;
            emit       = 1'b1;
            e_top      = cur_value;
            state_next = S_IDLE;
          end
        end else begin
          scan_idx_next = scan_idx + 1'b1;
          rd_en         = 1'b1;
          rd_addr       = scan_idx + 1'b1;
        end
      end
      S_TOP: begin
        if (out_free) begin
          emit       = 1'b1;
          e_status   = res_status;
          e_top      = rd_data;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[fill[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= entries[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    scan_idx   <= scan_idx_next;
    cur_value  <= cur_value_next;
    res_status <= res_status_next;
    if (emit) begin
      status    <= e_status;
      top_value <= e_top;
      count     <= COUNT_W'(fill_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("fill count above depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> fill != '0)
    else $error("scan on empty stack");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count == COUNT_W'(fill))
    else $error("result count differs from held count");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> count == '0 && top_value == '0)
    else $error("empty result with nonzero fields");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !cmd_take)
    else $error("command taken while busy");

endmodule

### sv/dedup_bounded_stack.sv
// Bounded LIFO stack that rejects duplicate values: top level.
//
// Input channel: in_valid / in_stall with kind (0 push, 1 pop) and push_value.
// A word is taken when in_valid is high and in_stall is low; a two-word queue
// sits behind the input, so in_stall rises only when that queue is full.
// Output channel: out_valid / out_stall with status, top_value and count,
// exactly one result word per input word, in order.
// A pop that empties the stack, a pop on empty, or a push onto an empty stack
// goes from the queue straight to the result register; a full push or a pop
// that leaves elements first reads the top from the entry memory in S_TOP; a
// push onto held elements first walks them in S_SCAN. The entry memory has one
// read port and the duplicate search walks the held entries one per cycle; one
// item is in the back end at a time, so it takes no new command until it emits.
// Reset clears the fill count, the queue and out_valid; entries and result fields are
// left as they are and only held ones are ever read.
// While out_stall is high with out_valid set, the result word holds, the back end
// waits before its next result, and the input keeps filling the queue until in_stall rises.
module dedup_bounded_stack
  import dbs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic signed [DATA_W-1:0]  push_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic signed [DATA_W-1:0]  top_value,
  output logic [COUNT_W-1:0]        count
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  dbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .push_value (push_value),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  dbs_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .top_value (top_value),
    .count     (count)
  );

endmodule
